[hdl/cle_pkg.sv]
`timescale 1ns / 1ps
// Package for the console line editor: buffer sizes, pointer arithmetic,
// character codes, result kinds and the line store request type. No dependencies.
package cle_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int PTR_MOD   = 2 * BUF_DEPTH;
    localparam int PTR_W     = $clog2(PTR_MOD);
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    typedef logic [7:0]        t_byte;
    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_byte CH_KILL = 8'h15;
    localparam t_byte CH_BS   = 8'h08;
    localparam t_byte CH_DEL  = 8'h7f;
    localparam t_byte CH_EOF  = 8'h04;
    localparam t_byte CH_CR   = 8'h0d;
    localparam t_byte CH_NL   = 8'h0a;
    localparam t_byte CH_NUL  = 8'h00;

    localparam logic OP_TYPE    = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_EMPTY = 2'd3
    } t_kind;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_byte wdata;
        logic  re;
        t_addr raddr;
    } t_ram_req;

    localparam t_ptr PTR_LAST = t_ptr'(PTR_MOD - 1);
    localparam t_ptr PTR_SPAN = t_ptr'(BUF_DEPTH);

    function automatic t_ptr ptr_inc(input t_ptr p);
        return (p == PTR_LAST) ? '0 : t_ptr'(p + 1'b1);
    endfunction

    function automatic t_ptr ptr_dec(input t_ptr p);
        return (p == '0) ? PTR_LAST : t_ptr'(p - 1'b1);
    endfunction

    function automatic logic [PTR_W:0] ptr_dist(input t_ptr a, input t_ptr b);
        logic [PTR_W:0] d;
        if (a >= b) begin
            d = {1'b0, a} - {1'b0, b};
        end else begin
            d = {1'b0, a} + (PTR_W+1)'(PTR_MOD) - {1'b0, b};
        end
        return d;
    endfunction

    function automatic t_addr slot(input t_ptr p);
        t_ptr s;
        s = (p >= PTR_SPAN) ? t_ptr'(p - PTR_SPAN) : p;
        return s[ADDR_W-1:0];
    endfunction

endpackage

[hdl/cle_line_ram.sv]
`timescale 1ns / 1ps
// Line store of the console line editor: one write port, one registered read port.
// Depends on cle_pkg.
module cle_line_ram (
    input  logic             i_clk,
    input  cle_pkg::t_ram_req i_req,
    output cle_pkg::t_byte   o_rdata
);
    import cle_pkg::*;

    t_byte r_mem [BUF_DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/console_line_editor.sv]
`timescale 1ns / 1ps
// Top level of the console line editor: sequencer, pointers and result register.
// Depends on cle_pkg and cle_line_ram.
//
// Usage:
//   Slave stream carries one transaction per request: tuser is the operation
//   (0 typed byte, 1 consume one committed byte), tdata the typed byte.
//   Master stream carries the results: tuser the kind (echo, erase sequence,
//   byte read, nothing committed), tdata the byte, tlast on the final result
//   of a request. Requests that cause no result (zero byte, full buffer,
//   erase with nothing uncommitted) produce no transaction.
//   One request is handled at a time; o_s_axis_tready is high only when the
//   sequencer is idle. A consume of a committed byte does one line store
//   read. Control-U erases back to the commit point or until it meets a
//   newline, with one line store read per step. The result register lets
//   the next request be taken while the last result still waits at the
//   master side.
//   Reset clears all pointers and the result valid flag; the line store is
//   not cleared. When the receiver stalls, the result is held and the
//   sequencer waits in place.
module console_line_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // typed_char[7:0]
    input  logic       i_s_axis_tuser,   // op[0]
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // data[7:0]
    output logic [1:0] o_m_axis_tuser,   // kind[1:0]
    output logic       o_m_axis_tlast
);
    import cle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_KILL = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state   r_state, n_state;
    t_ptr     r_rd_ptr, n_rd_ptr;
    t_ptr     r_cm_ptr, n_cm_ptr;
    t_ptr     r_ed_ptr, n_ed_ptr;
    logic     r_have, n_have;
    t_kind    r_pend_kind, n_pend_kind;
    t_byte    r_pend_data, n_pend_data;

    logic     r_out_valid;
    t_kind    r_out_kind;
    t_byte    r_out_data;
    logic     r_out_last;

    logic     w_out_free;
    logic     w_out_load;
    t_kind    w_out_kind;
    t_byte    w_out_data;
    logic     w_out_last;

    t_ram_req w_req;
    t_byte    w_rdata;
    t_byte    w_char;
    t_ptr     w_ed_inc;
    t_ptr     w_ed_dec;
    logic     w_accept;

    cle_line_ram u_ram (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_rdata(w_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_char          = (i_s_axis_tdata == CH_CR) ? CH_NL : i_s_axis_tdata;
    assign w_ed_inc        = ptr_inc(r_ed_ptr);
    assign w_ed_dec        = ptr_dec(r_ed_ptr);

    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_cm_ptr    = r_cm_ptr;
        n_ed_ptr    = r_ed_ptr;
        n_have      = r_have;
        n_pend_kind = r_pend_kind;
        n_pend_data = r_pend_data;
        w_req       = '0;
        w_out_load  = 1'b0;
        w_out_kind  = KIND_ERASE;
        w_out_data  = CH_NUL;
        w_out_last  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser == OP_CONSUME) begin
                        if (r_rd_ptr != r_cm_ptr) begin
                            w_req.re    = 1'b1;
                            w_req.raddr = slot(r_rd_ptr);
                            n_state     = S_READ;
                        end else begin
                            n_pend_kind = KIND_EMPTY;
                            n_pend_data = CH_NUL;
                            n_state     = S_EMIT;
                        end
                    end else if (i_s_axis_tdata == CH_KILL) begin
                        if (r_ed_ptr != r_cm_ptr) begin
                            w_req.re    = 1'b1;
                            w_req.raddr = slot(w_ed_dec);
                            n_have      = 1'b0;
                            n_state     = S_KILL;
                        end
                    end else if (i_s_axis_tdata == CH_BS || i_s_axis_tdata == CH_DEL) begin
                        if (r_ed_ptr != r_cm_ptr) begin
                            n_ed_ptr    = w_ed_dec;
                            n_pend_kind = KIND_ERASE;
                            n_pend_data = CH_NUL;
                            n_state     = S_EMIT;
                        end
                    end else if (i_s_axis_tdata != CH_NUL &&
                                 ptr_dist(r_ed_ptr, r_rd_ptr) < (PTR_W+1)'(BUF_DEPTH)) begin
                        w_req.we    = 1'b1;
                        w_req.waddr = slot(r_ed_ptr);
                        w_req.wdata = w_char;
                        n_ed_ptr    = w_ed_inc;
                        if (w_char == CH_NL || w_char == CH_EOF ||
                            ptr_dist(w_ed_inc, r_rd_ptr) == (PTR_W+1)'(BUF_DEPTH)) begin
                            n_cm_ptr = w_ed_inc;
                        end
                        n_pend_kind = KIND_ECHO;
                        n_pend_data = w_char;
                        n_state     = S_EMIT;
                    end
                end
            end
            S_READ: begin
                n_pend_kind = KIND_READ;
                n_pend_data = w_rdata;
                n_rd_ptr    = ptr_inc(r_rd_ptr);
                n_state     = S_EMIT;
            end
            S_KILL: begin
                if (w_rdata == CH_NL) begin
                    n_have = 1'b0;
                    if (r_have) begin
                        n_pend_kind = KIND_ERASE;
                        n_pend_data = CH_NUL;
                        n_state     = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (!r_have || w_out_free) begin
                    if (r_have) begin
                        w_out_load = 1'b1;
                        w_out_kind = KIND_ERASE;
                        w_out_data = CH_NUL;
                        w_out_last = 1'b0;
                    end
                    n_ed_ptr = w_ed_dec;
                    if (w_ed_dec == r_cm_ptr) begin
                        n_have      = 1'b0;
                        n_pend_kind = KIND_ERASE;
                        n_pend_data = CH_NUL;
                        n_state     = S_EMIT;
                    end else begin
                        n_have      = 1'b1;
                        w_req.re    = 1'b1;
                        w_req.raddr = slot(ptr_dec(w_ed_dec));
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_kind = r_pend_kind;
                    w_out_data = r_pend_data;
                    w_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_cm_ptr    <= '0;
            r_ed_ptr    <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_cm_ptr <= n_cm_ptr;
            r_ed_ptr <= n_ed_ptr;
            r_have   <= n_have;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_kind <= n_pend_kind;
        r_pend_data <= n_pend_data;
        if (w_out_load) begin
            r_out_kind <= w_out_kind;
            r_out_data <= w_out_data;
            r_out_last <= w_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

[hdl/cle_checker.sv]
`timescale 1ns / 1ps
// Port checker for the console line editor, bound to the top level.
// Depends on cle_pkg and console_line_editor.
module cle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);
    import cle_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result transaction withdrawn while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_ERASE || o_m_axis_tuser == KIND_EMPTY)
        |-> o_m_axis_tdata == CH_NUL)
        else $error("erase or empty result carries data");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_ECHO || o_m_axis_tuser == KIND_READ ||
                            o_m_axis_tuser == KIND_EMPTY)
        |-> o_m_axis_tlast)
        else $error("single result without tlast");

endmodule

bind console_line_editor cle_checker u_cle_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser),
    .o_m_axis_tlast (o_m_axis_tlast)
);
